>>> src/aesr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AES round package
// Byte tables, state types and GF(2^8) helpers shared by the round datapath.
// ----------------------------------------------------------------------------
package aesr_pkg;

  // Element 0 is the most significant byte, which is AES byte 0.
  typedef logic [0:15][7:0] state_t;
  typedef logic [0:3][7:0]  column_t;

  localparam logic [0:255][7:0] SboxFwd = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [0:255][7:0] SboxInv = {
    128'h52096ad53036a538bf40a39e81f3d7fb,
    128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e,
    128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692,
    128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506,
    128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673,
    128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b,
    128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f,
    128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961,
    128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
    return SboxFwd[b];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] b);
    return SboxInv[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic column_t mix_col(input column_t a);
    column_t    r;
    logic [7:0] d [4];
    for (int i = 0; i < 4; i++) begin
      d[i] = xtime(a[i]);
    end
    r[0] = d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3];
    r[1] = a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3];
    r[2] = a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3];
    r[3] = d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3];
    return r;
  endfunction

  function automatic column_t inv_mix_col(input column_t a);
    column_t    r;
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    for (int i = 0; i < 4; i++) begin
      x2[i]  = xtime(a[i]);
      x4[i]  = xtime(x2[i]);
      x8[i]  = xtime(x4[i]);
      m9[i]  = x8[i] ^ a[i];
      m11[i] = x8[i] ^ x2[i] ^ a[i];
      m13[i] = x8[i] ^ x4[i] ^ a[i];
      m14[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    r[0] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
    r[1] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
    r[2] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
    r[3] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/aesr_enc_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AES encrypt round
// SubBytes, ShiftRows and MixColumns, followed by the round key addition.
// ----------------------------------------------------------------------------
module aesr_enc_round
  import aesr_pkg::*;
(
  input  state_t state_i,
  input  state_t key_i,
  output state_t result_o
);

  state_t sub;
  state_t shf;
  state_t mix;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sub[i] = sbox_fwd(state_i[i]);
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        shf[r + 4 * c] = sub[r + 4 * ((c + r) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mix[4 * c +: 4] = mix_col(shf[4 * c +: 4]);
    end
    result_o = mix ^ key_i;
  end

endmodule
`default_nettype wire

>>> src/aesr_dec_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AES decrypt round
// Round key addition, followed by InvMixColumns, InvShiftRows and InvSubBytes.
// ----------------------------------------------------------------------------
module aesr_dec_round
  import aesr_pkg::*;
(
  input  state_t state_i,
  input  state_t key_i,
  output state_t result_o
);

  state_t add;
  state_t mix;
  state_t shf;

  always_comb begin
    add = state_i ^ key_i;
    for (int c = 0; c < 4; c++) begin
      mix[4 * c +: 4] = inv_mix_col(add[4 * c +: 4]);
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        shf[r + 4 * c] = mix[r + 4 * ((c - r + 4) % 4)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      result_o[i] = sbox_inv(shf[i]);
    end
  end

endmodule
`default_nettype wire

>>> src/aes_cipher_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// AES cipher round
// One full encrypt or decrypt AES round per word on a stream interface.
// ----------------------------------------------------------------------------
// An accepted word is held in the input register, passes the round logic
// into the result register and leaves when m_axis_tready is high.
// Throughput: one word per cycle while the output is not stalled, set by the
// input register feeding the round logic and the result register behind it.
// Reset: rst_ni clears both valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
module aes_cipher_round
  import aesr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // state_hi, state_lo, round_key_hi, round_key_lo
  input  logic [255:0] s_axis_tdata,
  // mode
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_hi, result_lo
  output logic [127:0] m_axis_tdata
);

  logic   in_vld_q;
  state_t in_state_q;
  state_t in_key_q;
  logic   in_mode_q;
  logic   out_vld_q;
  state_t out_data_q;

  state_t enc_res;
  state_t dec_res;
  state_t round_res;
  logic   out_ready;
  logic   in_adv;
  logic   s_fire;
  logic [127:0] out_bits;

  assign out_ready     = !out_vld_q || m_axis_tready;
  assign in_adv        = in_vld_q && out_ready;
  assign s_axis_tready = !in_vld_q || out_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  aesr_enc_round u_enc (
    .state_i  (in_state_q),
    .key_i    (in_key_q),
    .result_o (enc_res)
  );

  aesr_dec_round u_dec (
    .state_i  (in_state_q),
    .key_i    (in_key_q),
    .result_o (dec_res)
  );

  assign round_res = in_mode_q ? dec_res : enc_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_state_q <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
      in_key_q   <= {s_axis_tdata[191:128], s_axis_tdata[255:192]};
      in_mode_q  <= s_axis_tuser[0];
    end
    if (in_adv) begin
      out_data_q <= round_res;
    end
  end

  assign out_bits      = out_data_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_bits[63:0], out_bits[127:64]};

  a_fire_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> in_vld_q)
    else $error("accepted word did not reach the input register");

  a_adv_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv |=> out_vld_q)
    else $error("advancing word did not reach the result register");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_ready) |=> (in_vld_q && $stable(in_state_q)
                                  && $stable(in_mode_q)))
    else $error("input register changed while stalled");

  a_no_accept_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready) |-> !s_fire)
    else $error("word accepted while both stages were full");

endmodule
`default_nettype wire
